### hdl/tcw_pkg.sv
// Shared types, constants and an index helper for the text console writer.
// Depends on nothing; imported by every module of the block.
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;
   localparam int CELL_W  = $clog2(CELLS);
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;

   typedef enum logic [1:0] {
      OP_PUT  = 2'd0,
      OP_SET  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_FG = 1'b0,
      REG_BG = 1'b1
   } reg_index_type;

   typedef struct packed {
      op_type             operation;
      logic [7:0]         char_code;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   column;
   } req_type;

   typedef struct packed {
      logic [CELL_W-1:0]  cursor_index;
      logic [7:0]         cell_char;
      logic [7:0]         cell_attribute;
      logic               scrolled;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic clear_step;
      logic scroll_step;
      logic read_done;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic wrap;
      logic scroll_end;
      logic clear_end;
   } status_type;

   function automatic logic [CELL_W-1:0] clamp_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] column);
      logic [CELL_W-1:0] rr;
      logic [CELL_W-1:0] cc;
      rr = (CELL_W'(row) > CELL_W'(ROWS - 1)) ? CELL_W'(ROWS - 1) : CELL_W'(row);
      cc = (CELL_W'(column) > CELL_W'(COLUMNS - 1)) ? CELL_W'(COLUMNS - 1)
                                                    : CELL_W'(column);
      return CELL_W'(rr * CELL_W'(COLUMNS)) + cc;
   endfunction

endpackage

### hdl/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives commands into tcw_datapath.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  op_type     req_op,
   input  status_type status,
   output logic       req_ready,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_SCROLL = 5'b01000,
      ST_WIPE   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready  = status.rsp_free;
            cmd.accept = req_valid && status.rsp_free;
            if (cmd.accept) begin
               if (req_op == OP_READ) state_in = ST_READ;
               else if (req_op == OP_PUT && status.wrap) state_in = ST_SCROLL;
            end
         end
         ST_READ: begin
            cmd.read_done = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_end) state_in = ST_WIPE;
         end
         ST_WIPE: begin
            cmd.clear_step = 1'b1;
            if (status.clear_end) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

endmodule

### hdl/tcw_datapath.sv
// Datapath of the text console writer: cell memory, cursor, colors and result register.
// Depends on tcw_pkg; steered by tcw_ctrl.
module tcw_datapath
   import tcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  req_type       req_payload,
   input  logic          csr_we,
   input  reg_index_type csr_index,
   input  logic [3:0]    csr_wdata,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_type       rsp_payload,
   output status_type    status
);

   logic [15:0]       mem [CELLS];
   logic [15:0]       rdata_ff;
   logic [CELL_W-1:0] cursor_ff, cursor_in;
   logic [CELL_W-1:0] cnt_ff, cnt_in;
   logic [3:0]        fg_ff, bg_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              we, re;
   logic [CELL_W-1:0] waddr, raddr, req_index;
   logic [15:0]       wdata;
   logic              wrap;

   assign req_index = clamp_index(req_payload.row, req_payload.column);
   assign wrap      = (cursor_ff == CELL_W'(CELLS - 1));

   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;
   assign status.wrap       = wrap;
   assign status.scroll_end = (cnt_ff == CELL_W'(CELLS - COLUMNS));
   assign status.clear_end  = (cnt_ff == CELL_W'(CELLS - 1));

   always_comb begin
      we        = 1'b0;
      waddr     = cnt_ff;
      wdata     = '0;
      re        = 1'b0;
      raddr     = req_index;
      cursor_in = cursor_ff;
      cnt_in    = cnt_ff;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.clear_step) begin
         we     = 1'b1;
         cnt_in = cnt_ff + CELL_W'(1);
      end

      if (cmd.scroll_step) begin
         if (cnt_ff != '0) begin
            we    = 1'b1;
            waddr = cnt_ff - CELL_W'(1);
            wdata = rdata_ff;
         end
         if (!status.scroll_end) begin
            re     = 1'b1;
            raddr  = cnt_ff + CELL_W'(COLUMNS);
            cnt_in = cnt_ff + CELL_W'(1);
         end
      end

      if (cmd.read_done) begin
         rsp_in.cell_char      = rdata_ff[15:8];
         rsp_in.cell_attribute = rdata_ff[7:0];
         rsp_valid_in          = 1'b1;
      end

      if (cmd.accept) begin
         rsp_in.cell_char      = '0;
         rsp_in.cell_attribute = '0;
         rsp_in.scrolled       = 1'b0;
         case (req_payload.operation)
            OP_PUT: begin
               we    = 1'b1;
               waddr = cursor_ff;
               wdata = {req_payload.char_code, fg_ff, bg_ff};
               if (wrap) begin
                  cursor_in       = CELL_W'(CELLS - COLUMNS);
                  cnt_in          = '0;
                  rsp_in.scrolled = 1'b1;
               end else begin
                  cursor_in = cursor_ff + CELL_W'(1);
               end
            end
            OP_SET:  cursor_in = req_index;
            OP_READ: re = 1'b1;
            default: ;
         endcase
         rsp_in.cursor_index = cursor_in;
         rsp_valid_in        = (req_payload.operation != OP_READ);
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         cnt_ff       <= '0;
         fg_ff        <= 4'd0;
         bg_ff        <= 4'd15;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff    <= cursor_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == REG_FG) fg_ff <= csr_wdata;
         if (csr_we && csr_index == REG_BG) bg_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hdl/text_console_writer.sv
// Top level of the text console writer: a controller and a datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
// An 80x25 text screen store with a cursor. After reset the block clears its cell memory before
// it takes the first request; configuration writes are taken meanwhile. Set cursor and a put
// character that does not wrap leave the controller idle; read cell passes through a read state
// because the memory read is registered. A put character that passes the last cell scrolls the
// screen: the copy reads one cell and writes one cell a cycle, then the bottom row is cleared.
// The result of a request waits in an output register, and the next request is taken in the
// cycle that register is emptied.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_payload,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_payload,
   input  logic          csr_we,
   input  reg_index_type csr_index,
   input  logic [3:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.operation),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .status      (status)
   );

`ifndef SYNTHESIS
   a_busy_after_reset: assert property (@(posedge clock) $past(reset) |-> !req_ready)
      else $error("request taken during the clearing pass");

   a_scroll_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.operation == OP_PUT && status.wrap)
      |=> !req_ready)
      else $error("request taken while the screen scrolls");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.cursor_index < CELL_W'(CELLS)))
      else $error("cursor index outside the screen");
`endif

endmodule
